[design/ppdm_pkg.sv]
`timescale 1ns / 1ps

package ppdm_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CLOCK_WIDTH = 30;
    localparam int DUTY_WIDTH  = 14;

    localparam int DUTY_STEPS  = DUTY_WIDTH;
    localparam int FREQ_STEPS  = CLOCK_WIDTH;
    localparam int STEP_WIDTH  = $clog2(FREQ_STEPS);
    localparam int EXT_WIDTH   = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
    localparam int DNUM_WIDTH  = COUNT_WIDTH + DUTY_WIDTH;

    localparam logic [DUTY_WIDTH-1:0]  DUTY_SCALE  = DUTY_WIDTH'(10000);
    localparam logic [CLOCK_WIDTH-1:0] CLOCK_RESET = CLOCK_WIDTH'(24000000);
    localparam logic [OUT_WIDTH-1:0]   OUT_MAX     = {OUT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [DNUM_WIDTH-1:0]  t_dnum;
    typedef logic [CLOCK_WIDTH-1:0] t_clock;
    typedef logic [DUTY_WIDTH-1:0]  t_duty;
    typedef logic [OUT_WIDTH-1:0]   t_out;
    typedef logic [STEP_WIDTH-1:0]  t_step;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;        // restart both counters at one
        logic bump_high;
        logic bump_period;
        logic div_load;     // capture finished counts into the divider
        logic div_step;
        logic out_load;     // move divider results to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;     // the current divider step is the final one
    } t_dp_stat;

endpackage

[design/ppdm_dp.sv]
`timescale 1ns / 1ps

module ppdm_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ppdm_pkg::t_clock      i_cfg_data,
    input  ppdm_pkg::t_dp_cmd     i_cmd,
    output ppdm_pkg::t_dp_stat    o_stat,
    output ppdm_pkg::t_out        o_high_ticks,
    output ppdm_pkg::t_out        o_period_ticks,
    output ppdm_pkg::t_duty       o_duty_hundredths,
    output ppdm_pkg::t_clock      o_frequency_hz,
    output logic                  o_overflow
);
    import ppdm_pkg::*;

    t_clock r_clock_hz, n_clock_hz;

    t_count r_high, n_high;
    t_count r_period, n_period;
    logic   r_sat, n_sat;

    // divider state
    t_step  r_step, n_step;
    t_dnum  r_dnum, n_dnum;
    t_dnum  r_dden, n_dden;
    t_duty  r_dq, n_dq;
    t_count r_p, n_p;
    t_count r_frem, n_frem;
    t_clock r_fnum, n_fnum;
    t_clock r_fq, n_fq;
    t_out   r_h_out, n_h_out;
    t_out   r_p_out, n_p_out;
    logic   r_ovf, n_ovf;

    // output register
    t_out   r_o_high, n_o_high;
    t_out   r_o_period, n_o_period;
    t_duty  r_o_duty, n_o_duty;
    t_clock r_o_freq, n_o_freq;
    logic   r_o_ovf, n_o_ovf;

    logic [EXT_WIDTH-1:0]   high_ext, period_ext;
    logic                   high_over, period_over;
    logic                   high_full, period_full;
    logic [COUNT_WIDTH:0]   f_trial;
    logic                   f_ge;
    logic                   d_ge;
    logic                   duty_active;

    assign high_full   = (r_high == {COUNT_WIDTH{1'b1}});
    assign period_full = (r_period == {COUNT_WIDTH{1'b1}});
    assign high_ext    = EXT_WIDTH'(r_high);
    assign period_ext  = EXT_WIDTH'(r_period);
    assign high_over   = high_ext > EXT_WIDTH'(OUT_MAX);
    assign period_over = period_ext > EXT_WIDTH'(OUT_MAX);

    assign f_trial     = {r_frem, r_fnum[CLOCK_WIDTH-1]};
    assign f_ge        = f_trial >= {1'b0, r_p};
    assign d_ge        = r_dnum >= r_dden;
    assign duty_active = r_step < STEP_WIDTH'(DUTY_STEPS);

    assign o_stat.div_last = (r_step == STEP_WIDTH'(FREQ_STEPS - 1));

    always_comb begin
        n_clock_hz = i_cfg_we ? i_cfg_data : r_clock_hz;

        n_high   = r_high;
        n_period = r_period;
        n_sat    = r_sat;
        if (i_cmd.start) begin
            n_high   = COUNT_WIDTH'(1);
            n_period = COUNT_WIDTH'(1);
            n_sat    = 1'b0;
        end else begin
            if (i_cmd.bump_high) begin
                if (high_full) n_sat = 1'b1;
                else           n_high = r_high + COUNT_WIDTH'(1);
            end
            if (i_cmd.bump_period) begin
                if (period_full) n_sat = 1'b1;
                else             n_period = r_period + COUNT_WIDTH'(1);
            end
        end

        n_step  = r_step;
        n_dnum  = r_dnum;
        n_dden  = r_dden;
        n_dq    = r_dq;
        n_p     = r_p;
        n_frem  = r_frem;
        n_fnum  = r_fnum;
        n_fq    = r_fq;
        n_h_out = r_h_out;
        n_p_out = r_p_out;
        n_ovf   = r_ovf;
        if (i_cmd.div_load) begin
            n_step  = '0;
            n_dnum  = t_dnum'(r_high) * t_dnum'(DUTY_SCALE);
            n_dden  = t_dnum'(r_period) << (DUTY_STEPS - 1);
            n_dq    = '0;
            n_p     = r_period;
            n_frem  = '0;
            n_fnum  = r_clock_hz;
            n_fq    = '0;
            n_h_out = high_over ? OUT_MAX : OUT_WIDTH'(high_ext);
            n_p_out = period_over ? OUT_MAX : OUT_WIDTH'(period_ext);
            n_ovf   = r_sat || high_over || period_over;
        end else if (i_cmd.div_step) begin
            n_step = r_step + STEP_WIDTH'(1);
            // duty: restoring division with a shifting divisor
            if (duty_active) begin
                if (d_ge) n_dnum = r_dnum - r_dden;
                n_dq   = {r_dq[DUTY_WIDTH-2:0], d_ge};
                n_dden = r_dden >> 1;
            end
            // frequency: one quotient bit per step, dividend bits msb first
            n_frem = f_ge ? COUNT_WIDTH'(f_trial - {1'b0, r_p}) : COUNT_WIDTH'(f_trial);
            n_fnum = {r_fnum[CLOCK_WIDTH-2:0], 1'b0};
            n_fq   = {r_fq[CLOCK_WIDTH-2:0], f_ge};
        end

        n_o_high   = r_o_high;
        n_o_period = r_o_period;
        n_o_duty   = r_o_duty;
        n_o_freq   = r_o_freq;
        n_o_ovf    = r_o_ovf;
        if (i_cmd.out_load) begin
            n_o_high   = r_h_out;
            n_o_period = r_p_out;
            n_o_duty   = (r_p == '0) ? '0 : r_dq;
            n_o_freq   = (r_p == '0) ? '0 : r_fq;
            n_o_ovf    = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_RESET;
            r_high     <= '0;
            r_period   <= '0;
            r_sat      <= 1'b0;
            r_step     <= '0;
        end else begin
            r_clock_hz <= n_clock_hz;
            r_high     <= n_high;
            r_period   <= n_period;
            r_sat      <= n_sat;
            r_step     <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dnum     <= n_dnum;
        r_dden     <= n_dden;
        r_dq       <= n_dq;
        r_p        <= n_p;
        r_frem     <= n_frem;
        r_fnum     <= n_fnum;
        r_fq       <= n_fq;
        r_h_out    <= n_h_out;
        r_p_out    <= n_p_out;
        r_ovf      <= n_ovf;
        r_o_high   <= n_o_high;
        r_o_period <= n_o_period;
        r_o_duty   <= n_o_duty;
        r_o_freq   <= n_o_freq;
        r_o_ovf    <= n_o_ovf;
    end

    assign o_high_ticks      = r_o_high;
    assign o_period_ticks    = r_o_period;
    assign o_duty_hundredths = r_o_duty;
    assign o_frequency_hz    = r_o_freq;
    assign o_overflow        = r_o_ovf;

endmodule

[design/ppdm_ctrl.sv]
`timescale 1ns / 1ps

module ppdm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_pin_level,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ppdm_pkg::t_dp_cmd     o_cmd,
    input  ppdm_pkg::t_dp_stat    i_stat
);
    import ppdm_pkg::*;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_HIGH = 3'b010,
        PH_LOW  = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_HOLD = 3'b100
    } t_div;

    t_phase r_phase, n_phase;
    t_div   r_div, n_div;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    // only an item that closes a measurement has to wait for the divider
    assign o_in_stall = (r_phase == PH_LOW) && i_pin_level && (r_div != DIV_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_HIGH: begin
                    o_cmd.bump_period = 1'b1;
                    if (i_pin_level) o_cmd.bump_high = 1'b1;
                    else             n_phase = PH_LOW;
                end
                PH_LOW: begin
                    if (i_pin_level) begin
                        o_cmd.div_load = 1'b1;
                        o_cmd.start    = 1'b1;
                        n_phase        = PH_HIGH;
                    end else begin
                        o_cmd.bump_period = 1'b1;
                    end
                end
                default: begin
                    if (i_pin_level) begin
                        o_cmd.start = 1'b1;
                        n_phase     = PH_HIGH;
                    end else begin
                        n_phase = PH_WAIT;
                    end
                end
            endcase
        end

        n_div = r_div;
        unique case (r_div)
            DIV_IDLE: begin
                if (o_cmd.div_load) n_div = DIV_RUN;
            end
            DIV_RUN: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_div = DIV_HOLD;
            end
            DIV_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_div          = DIV_IDLE;
                end
            end
            default: n_div = DIV_IDLE;
        endcase

        if (o_cmd.out_load)   n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_div       <= DIV_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_div       <= n_div;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_load |-> (r_div == DIV_IDLE))
        else $error("divider loaded while busy");

    a_last_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div == DIV_RUN) && i_stat.div_last |=> (r_div == DIV_HOLD))
        else $error("divider did not finish after last step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_load |-> o_cmd.start && (r_phase == PH_LOW))
        else $error("capture without restart of the counters");

endmodule

[design/pwm_period_duty_meter.sv]
`timescale 1ns / 1ps

// pwm input capture: period, high time, duty cycle and frequency of a pulse pin
//
// input channel: one item per clock tick, i_pin_level is the sampled pin level;
//   an item is taken when i_in_valid is high and o_in_stall is low
// output channel: one item per measured period (rising edge to rising edge),
//   held in an output register while i_out_stall is high
// configuration: i_cfg_we writes i_cfg_data into clock_hz (reset 24000000)
//
// after reset the meter waits for a high sample, then counts the high part and
// the low part; the sample carrying the next rising edge closes the measurement
// and is also the first tick of the next one
// result path: the closing item is captured at the accepting edge, the 30 divider
//   steps run, then the result moves into the output register once that register
//   is free (not holding an item while i_out_stall is high)
// throughput: one pin sample per cycle; the 30-step shared divider runs beside the
//   counters, so o_in_stall rises only for a closing item that arrives while the
//   previous result is still dividing or waiting behind a stalled receiver
// a receiver stall holds the output item; the counters keep running meanwhile
// counters saturate at all ones and flag overflow in the result
module pwm_period_duty_meter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ppdm_pkg::t_clock      i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_pin_level,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ppdm_pkg::t_out        o_high_ticks,
    output ppdm_pkg::t_out        o_period_ticks,
    output ppdm_pkg::t_duty       o_duty_hundredths,
    output ppdm_pkg::t_clock      o_frequency_hz,
    output logic                  o_overflow
);
    import ppdm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // phase tracking, divider sequencing and output handshake
    ppdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_pin_level (i_pin_level),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // counters, clock_hz register, duty and frequency divider, output register
    ppdm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_high_ticks      (o_high_ticks),
        .o_period_ticks    (o_period_ticks),
        .o_duty_hundredths (o_duty_hundredths),
        .o_frequency_hz    (o_frequency_hz),
        .o_overflow        (o_overflow)
    );

endmodule

[tb/sv/tb_pwm_period_duty_meter.sv]
`timescale 1ns / 1ps

module tb_pwm_period_duty_meter;
    import ppdm_pkg::*;

    // run limit, far above the slowest correct run
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // result latency of the meter plus margin, used before register writes and at the end
    localparam int unsigned SETTLE_TICKS = 48;
    // random pin samples spread over the clock settings below
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int          NUM_SETTINGS = 7;

    typedef enum logic [1:0] {
        MEAS_WAIT = 2'd0,
        MEAS_HIGH = 2'd1,
        MEAS_LOW  = 2'd2
    } t_meas_phase;

    typedef struct packed {
        t_out   high_ticks;
        t_out   period_ticks;
        t_duty  duty_hundredths;
        t_clock frequency_hz;
        logic   overflow;
    } t_meter_result;

    // one run of constant pin level; a typed result belongs to the first sample of the run
    typedef struct {
        logic          level;
        int unsigned   len;
        bit            typed;
        t_meter_result want;
    } t_pin_run;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_cfg_we    = 1'b0;
    t_clock i_cfg_data  = '0;
    logic   i_in_valid  = 1'b0;
    logic   i_pin_level = 1'b0;
    logic   i_out_stall = 1'b0;
    logic   o_in_stall;
    logic   o_out_valid;
    t_out   o_high_ticks;
    t_out   o_period_ticks;
    t_duty  o_duty_hundredths;
    t_clock o_frequency_hz;
    logic   o_overflow;

    pwm_period_duty_meter dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pin_level       (i_pin_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_high_ticks      (o_high_ticks),
        .o_period_ticks    (o_period_ticks),
        .o_duty_hundredths (o_duty_hundredths),
        .o_frequency_hz    (o_frequency_hz),
        .o_overflow        (o_overflow)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the meter: measurement phase, both counters, saturation flag, clock_hz
    t_meas_phase   meas_phase = MEAS_WAIT;
    t_count        high_cnt   = '0;
    t_count        period_cnt = '0;
    logic          meas_sat   = 1'b0;
    t_clock        clock_cfg  = CLOCK_RESET;

    t_meter_result awaited_results[$];
    t_pin_run      directed_runs[$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   sent_items  = 0;
    int unsigned   burst_left  = 0;

    // saturating counter step, sticky flag on saturation
    function automatic t_count count_up(input t_count c);
        if (&c) begin
            meas_sat = 1'b1;
            return c;
        end
        return c + 1'b1;
    endfunction

    // advance the shadow by one pin sample; returns 1 when the sample closes a period
    function automatic bit measure_sample(input logic level, output t_meter_result res);
        logic [63:0]  h;
        logic [63:0]  p;
        logic [127:0] scaled;
        logic         ovf;
        bit           closes;
        res    = '0;
        closes = 1'b0;
        if (meas_phase == MEAS_HIGH) begin
            if (level) high_cnt = count_up(high_cnt);
            else meas_phase = MEAS_LOW;
            period_cnt = count_up(period_cnt);
            return 1'b0;
        end
        if (meas_phase == MEAS_LOW) begin
            if (!level) begin
                period_cnt = count_up(period_cnt);
                return 1'b0;
            end
            h   = 64'(high_cnt);
            p   = 64'(period_cnt);
            ovf = meas_sat;
            // counts wider than the output fields clamp and flag overflow
            if (h > 64'(OUT_MAX) || p > 64'(OUT_MAX)) ovf = 1'b1;
            res.high_ticks   = (h > 64'(OUT_MAX)) ? OUT_MAX : t_out'(h);
            res.period_ticks = (p > 64'(OUT_MAX)) ? OUT_MAX : t_out'(p);
            if (p != 0) begin
                if (h > p) h = p;
                scaled = 128'(h) * 128'(DUTY_SCALE);
                res.duty_hundredths = t_duty'(scaled / 128'(p));
                res.frequency_hz    = t_clock'(64'(clock_cfg) / p);
            end
            res.overflow = ovf;
            closes       = 1'b1;
        end
        // waiting, or closing a period: a high sample opens the next measurement
        if (level) begin
            meas_phase = MEAS_HIGH;
            high_cnt   = 1;
            period_cnt = 1;
            meas_sat   = 1'b0;
        end else begin
            meas_phase = MEAS_WAIT;
        end
        return closes;
    endfunction

    // one pin sample through the input handshake, with sender bursts and gaps
    task automatic send_sample(input logic level, input bit typed, input t_meter_result want);
        t_meter_result res;
        int unsigned   gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid  <= 1'b1;
        i_pin_level <= level;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        sent_items++;
        if (measure_sample(level, res)) awaited_results.push_back(typed ? want : res);
    endtask

    task automatic send_pulse(input int unsigned high_len, input int unsigned low_len);
        repeat (high_len) send_sample(1'b1, 1'b0, '0);
        repeat (low_len) send_sample(1'b0, 1'b0, '0);
    endtask

    // wait for every pending result, then for the divider to go quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_clock(input t_clock value);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        clock_cfg = value;
    endtask

    task automatic add_run(input logic level, input int unsigned len, input bit typed,
                           input t_out h, input t_out p, input t_duty d, input t_clock f);
        t_pin_run r;
        r.level = level;
        r.len   = len;
        r.typed = typed;
        r.want  = '{high_ticks: h, period_ticks: p, duty_hundredths: d,
                    frequency_hz: f, overflow: 1'b0};
        directed_runs.push_back(r);
    endtask

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // result monitor: every accepted item against the oldest expectation
    always @(posedge i_clk) begin
        t_meter_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual high %0d period %0d",
                         $time, o_high_ticks, o_period_ticks);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("high_ticks", want.high_ticks, o_high_ticks);
                check_field("period_ticks", want.period_ticks, o_period_ticks);
                check_field("duty_hundredths", want.duty_hundredths, o_duty_hundredths);
                check_field("frequency_hz", want.frequency_hz, o_frequency_hz);
                check_field("overflow", want.overflow, o_overflow);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_pwm_period_duty_meter: FAIL");
            $finish;
        end
    end

    // receiver stall pattern: free stretches, fine chatter, and long holds
    initial begin : out_stall_pattern
        int unsigned style;
        int unsigned n;
        @(posedge i_rst_n);
        forever begin
            style = $urandom_range(3);
            case (style)
                0: begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(20, 200)) @(posedge i_clk);
                end
                1: begin
                    n = $urandom_range(5, 15);
                    repeat (n) begin
                        i_out_stall <= 1'b1;
                        @(posedge i_clk);
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(1, 3)) @(posedge i_clk);
                    end
                end
                default: begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            endcase
        end
    end

    initial begin : stimulus
        t_clock      settings[NUM_SETTINGS];
        int unsigned budget;
        int unsigned k;
        int unsigned n;

        // directed pulses at the reset clock of 24 MHz; leading lows are ignored while waiting
        add_run(1'b0, 2, 1'b0, 0, 0, 0, 0);
        add_run(1'b1, 1, 1'b0, 0, 0, 0, 0);
        add_run(1'b0, 1, 1'b0, 0, 0, 0, 0);
        // shortest period: one high, one low
        add_run(1'b1, 3, 1'b1, 1, 2, 5000, 12000000);
        add_run(1'b0, 1, 1'b0, 0, 0, 0, 0);
        add_run(1'b1, 1, 1'b1, 3, 4, 7500, 6000000);
        add_run(1'b0, 3, 1'b0, 0, 0, 0, 0);
        add_run(1'b1, 2, 1'b1, 1, 4, 2500, 6000000);
        add_run(1'b0, 1, 1'b0, 0, 0, 0, 0);
        // duty rounds down
        add_run(1'b1, 1, 1'b1, 2, 3, 6666, 8000000);
        add_run(1'b0, 5, 1'b0, 0, 0, 0, 0);
        add_run(1'b1, 1, 1'b1, 1, 6, 1666, 4000000);

        // clock settings per random section: extremes, zero clock, all ones, random, reset value
        settings[0] = t_clock'(1);
        settings[1] = t_clock'(1000000000);
        settings[2] = '0;
        settings[3] = '1;
        settings[4] = t_clock'($urandom_range(1, 1000000000));
        settings[5] = t_clock'($urandom());
        settings[6] = CLOCK_RESET;

        // hold the synchronous reset, then release it
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_runs[i]) begin
            for (int unsigned j = 0; j < directed_runs[i].len; j++)
                send_sample(directed_runs[i].level, directed_runs[i].typed && j == 0,
                            directed_runs[i].want);
        end

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain_results();
            write_clock(settings[s]);
            budget = sent_items + RANDOM_ITEMS / NUM_SETTINGS;
            while (sent_items < budget) begin
                k = $urandom_range(99);
                if (k < 8) begin
                    // noise: arbitrary pin levels
                    n = $urandom_range(4, 24);
                    repeat (n) send_sample(1'(($urandom() >> 7) & 1), 1'b0, '0);
                end else if (k < 10) begin
                    // one long side
                    if ($urandom_range(1)) send_pulse($urandom_range(50, 400),
                                                      $urandom_range(1, 8));
                    else send_pulse($urandom_range(1, 8), $urandom_range(50, 400));
                end else if (k < 30) begin
                    send_pulse($urandom_range(1, 40), $urandom_range(1, 40));
                end else begin
                    send_pulse($urandom_range(1, 8), $urandom_range(1, 8));
                end
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("tb_pwm_period_duty_meter: PASS");
        end else begin
            $display("tb_pwm_period_duty_meter: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
design/ppdm_pkg.sv
design/ppdm_dp.sv
design/ppdm_ctrl.sv
design/pwm_period_duty_meter.sv
tb/sv/tb_pwm_period_duty_meter.sv
